[hdl/urm_pkg.sv]
// Shared types and constants of the ultrasonic range measurer.
package urm_pkg;

    // Measurement phases.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TRIG    = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_WAIT    = 3'd3,
        PH_MEASURE = 3'd4
    } phase_t;

    localparam int CNT_W   = 24;
    localparam int TRIG_W  = 16;
    localparam int SETTL_W = 16;
    localparam int TOUT_W  = 24;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 16;
    localparam int PROD_W  = CNT_W + SCALE_W;
    localparam int FRAC_W  = 24;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 24;

    // Register byte addresses.
    localparam logic [ADDR_W-1:0] ADDR_TRIGGER = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_SETTLE  = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_TIMEOUT = 4'h8;
    localparam logic [ADDR_W-1:0] ADDR_SCALE   = 4'hC;

    // Register reset values.
    localparam logic [TRIG_W-1:0]  TRIGGER_RST = 16'd1000;
    localparam logic [SETTL_W-1:0] SETTLE_RST  = 16'd1500;
    localparam logic [TOUT_W-1:0]  TIMEOUT_RST = 24'd400000;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd14260;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

[hdl/ultrasonic_range_measurer.sv]
// Ultrasonic echo-pulse range measurer: one sensor, tick-driven stream in and out.
// A word accepted on the input passes the input register and the result register
// before it is presented. Throughput: one word per cycle unless m_tready stalls;
// the phase logic updates its state once per word.
// Reset (rst_n low, asynchronous): idle phase, counters and distance cleared,
// registers back to 1000 / 1500 / 400000 / 14260, both pipeline stages empty.
module ultrasonic_range_measurer
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: [0] start_req, [1] echo_level, [7:2] zero
    input  logic [urm_pkg::IN_W-1:0]    s_tdata,
    // Output stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: [0] trigger_level, [1] busy_res, [2] done_res, [3] timed_out,
    //          [19:4] distance, [23:20] zero
    output logic [urm_pkg::OUT_W-1:0]   m_tdata,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [urm_pkg::ADDR_W-1:0]  paddr,
    input  logic [urm_pkg::DATA_W-1:0]  pwdata,
    output logic [urm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import urm_pkg::*;

    // Configuration registers.
    logic [TRIG_W-1:0]  trigger_ticks_reg;
    logic [SETTL_W-1:0] settle_ticks_reg;
    logic [TOUT_W-1:0]  timeout_ticks_reg;
    logic [SCALE_W-1:0] distance_scale_reg;

    // Input stage.
    logic in_valid_reg;
    logic in_start_reg;
    logic in_echo_reg;

    // Measurement state.
    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   width_reg, width_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;

    // Result stage.
    logic               out_valid_reg;
    logic               out_trig_reg;
    logic               out_busy_reg;
    logic               out_done_reg;
    logic               out_tout_reg;
    logic [DIST_W-1:0]  out_dist_reg;

    logic done_next;
    logic tout_next;
    logic advance;
    logic cfg_wr;

    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  wait_base;
    logic [CNT_W-1:0]  wait_inc;
    logic              settle_over;
    logic [PROD_W-1:0] product;

    // The stored word moves into the result register when that register is
    // empty or being drained; the input stage refills in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_TRIGGER: prdata = DATA_W'(trigger_ticks_reg);
            ADDR_SETTLE:  prdata = DATA_W'(settle_ticks_reg);
            ADDR_TIMEOUT: prdata = DATA_W'(timeout_ticks_reg);
            ADDR_SCALE:   prdata = DATA_W'(distance_scale_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg  <= TRIGGER_RST;
            settle_ticks_reg   <= SETTLE_RST;
            timeout_ticks_reg  <= TIMEOUT_RST;
            distance_scale_reg <= SCALE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                ADDR_TRIGGER: trigger_ticks_reg  <= pwdata[TRIG_W-1:0];
                ADDR_SETTLE:  settle_ticks_reg   <= pwdata[SETTL_W-1:0];
                ADDR_TIMEOUT: timeout_ticks_reg  <= pwdata[TOUT_W-1:0];
                ADDR_SCALE:   distance_scale_reg <= pwdata[SCALE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Shared counter arithmetic. When the settle phase runs out, the echo is
    // sampled on that same tick with the wait counter starting from zero.
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign settle_over = (cnt_reg >= CNT_W'(settle_ticks_reg));
    assign wait_base   = (phase_reg == PH_SETTLE) ? '0 : cnt_reg;
    assign wait_inc    = wait_base + CNT_W'(1);

    // The full product of a 24-bit width and a 16-bit Q0.24 scale, shifted
    // right by 24, never exceeds 16 bits, so no saturation is needed.
    assign product = PROD_W'(width_reg) * PROD_W'(distance_scale_reg);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        width_next = width_reg;
        dist_next  = dist_reg;
        done_next  = 1'b0;
        tout_next  = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_start_reg)
                begin
                    phase_next = PH_TRIG;
                    cnt_next   = '0;
                end
            end
            PH_TRIG:
            begin
                // A zero trigger length behaves as one tick.
                if (cnt_inc >= CNT_W'(trigger_ticks_reg))
                begin
                    phase_next = PH_SETTLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_SETTLE, PH_WAIT:
            begin
                if (phase_reg == PH_SETTLE && !settle_over)
                begin
                    cnt_next = cnt_inc;
                end
                else if (in_echo_reg)
                begin
                    phase_next = PH_MEASURE;
                    cnt_next   = wait_base;
                    width_next = CNT_W'(1);
                end
                else if (wait_inc >= timeout_ticks_reg)
                begin
                    // Give up at once; the old distance stays.
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    tout_next  = 1'b1;
                end
                else
                begin
                    phase_next = PH_WAIT;
                    cnt_next   = wait_inc;
                end
            end
            PH_MEASURE:
            begin
                if (in_echo_reg)
                begin
                    if (width_reg != CNT_MAX)
                    begin
                        width_next = width_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    dist_next  = product[FRAC_W +: DIST_W];
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            width_reg     <= '0;
            dist_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                width_reg     <= width_next;
                dist_reg      <= dist_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_start_reg <= s_tdata[0];
            in_echo_reg  <= s_tdata[1];
        end
        if (advance)
        begin
            out_trig_reg <= (phase_next == PH_TRIG);
            out_busy_reg <= (phase_next != PH_IDLE);
            out_done_reg <= done_next;
            out_tout_reg <= tout_next;
            out_dist_reg <= dist_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_dist_reg, out_tout_reg, out_done_reg,
                       out_busy_reg, out_trig_reg};

endmodule
